@@ src/pgm_hdr_pkg.sv @@
// Shared types and status codes for the PGM header parser.
`default_nettype none

package pgm_hdr_pkg;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC  = 3'd1;
    localparam logic [2:0] ST_BAD_NUMBER = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
    localparam logic [2:0] ST_TRUNCATED  = 3'd4;

    localparam int OUT_DIM_W = 16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [OUT_DIM_W-1:0] image_width;
        logic [OUT_DIM_W-1:0] image_height;
        logic [OUT_DIM_W-1:0] max_value;
        logic                 binary_pixels;
    } res_item_t;

endpackage

`default_nettype wire

@@ src/pgm_header_parser.sv @@
// A byte is registered in the input stage on accept, and its result, if any, is
// registered when the parser takes the byte from that stage, and m_valid rises.
// Throughput: one byte per cycle; the parser state advances once per byte.
// A full result register that is not taken holds the byte stage, and s_ready drops.
// Reset (aresetn low, synchronous) empties both stages and returns the parser to
// waiting for the magic letter; first_byte restarts it the same way.
`default_nettype none

module pgm_header_parser #(
    parameter int DIM_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_first_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [15:0]      m_image_width,
    output logic [15:0]      m_image_height,
    output logic [15:0]      m_max_value,
    output logic             m_binary_pixels
);

    pgm_hdr_pkg::in_item_t  s_item;
    pgm_hdr_pkg::in_item_t  item;
    pgm_hdr_pkg::res_item_t res;
    pgm_hdr_pkg::res_item_t m_item;
    logic                   item_valid;
    logic                   proc_en;
    logic                   res_valid;

    assign s_item.data_byte  = s_data_byte;
    assign s_item.first_byte = s_first_byte;
    assign s_item.last_byte  = s_last_byte;

    // advance the held byte when the result register is free or draining
    assign proc_en = item_valid && (!m_valid || m_ready);

    pgm_hdr_in_stage u_in (
        .clk        (aclk),
        .rstn       (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (proc_en),
        .item_valid (item_valid),
        .item       (item)
    );

    pgm_hdr_core #(
        .DIM_BITS (DIM_BITS)
    ) u_core (
        .clk       (aclk),
        .rstn      (aresetn),
        .proc_en   (proc_en),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    pgm_hdr_out_stage u_out (
        .clk       (aclk),
        .rstn      (aresetn),
        .load      (proc_en),
        .res_valid (res_valid),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    assign m_status        = m_item.status;
    assign m_image_width   = m_item.image_width;
    assign m_image_height  = m_item.image_height;
    assign m_max_value     = m_item.max_value;
    assign m_binary_pixels = m_item.binary_pixels;

endmodule

`default_nettype wire

@@ src/pgm_hdr_in_stage.sv @@
// Input register stage: holds one incoming byte item until the parser takes it.
`default_nettype none

module pgm_hdr_in_stage (
    input  wire logic                 clk,
    input  wire logic                 rstn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire pgm_hdr_pkg::in_item_t s_item,
    input  wire logic                 take,
    output logic                      item_valid,
    output pgm_hdr_pkg::in_item_t     item
);

    logic                  valid_reg;
    pgm_hdr_pkg::in_item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

@@ src/pgm_hdr_core.sv @@
// Parser state and next-state logic: magic check, tokenizer and number accumulation.
`default_nettype none

module pgm_hdr_core #(
    parameter int DIM_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rstn,
    input  wire logic                  proc_en,
    input  wire pgm_hdr_pkg::in_item_t item,
    output logic                       res_valid,
    output pgm_hdr_pkg::res_item_t     res
);

    localparam int ACC_W  = ((DIM_BITS > pgm_hdr_pkg::OUT_DIM_W) ? DIM_BITS
                                                                 : pgm_hdr_pkg::OUT_DIM_W) + 1;
    localparam int PROD_W = ACC_W + 4;

    localparam logic [ACC_W-1:0] ACC_CAP   = ACC_W'(1) << (ACC_W - 1);
    localparam logic [ACC_W-1:0] DIM_LIMIT = (ACC_W'(1) << DIM_BITS) - ACC_W'(1);
    localparam logic [ACC_W-1:0] MV_LIMIT  = ACC_W'(17'h0FFFF);

    // magic phase codes
    localparam logic [1:0] MP_P     = 2'd0;
    localparam logic [1:0] MP_DIGIT = 2'd1;
    localparam logic [1:0] MP_SEP   = 2'd2;
    localparam logic [1:0] MP_HDR   = 2'd3;

    // token phase codes
    localparam logic [1:0] TP_IDLE    = 2'd0;
    localparam logic [1:0] TP_TOKEN   = 2'd1;
    localparam logic [1:0] TP_COMMENT = 2'd2;

    localparam int FLAG_SIGN  = 0;
    localparam int FLAG_NEG   = 1;
    localparam int FLAG_DIGIT = 2;
    localparam int FLAG_BAD   = 3;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_2     = 8'h32;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    logic [1:0]       magic_reg,   magic_next;
    logic [1:0]       tphase_reg,  tphase_next;
    logic [1:0]       tdone_reg,   tdone_next;
    logic [ACC_W-1:0] acc_reg,     acc_next;
    logic [3:0]       flags_reg,   flags_next;
    logic [15:0]      hwidth_reg,  hwidth_next;
    logic [15:0]      hheight_reg, hheight_next;
    logic [2:0]       perr_reg,    perr_next;
    logic             fmt_reg,     fmt_next;
    logic             fin_reg,     fin_next;

    // current state after an optional restart
    logic [1:0]        cur_magic, cur_tphase, cur_tdone;
    logic [ACC_W-1:0]  cur_acc;
    logic [3:0]        cur_flags;
    logic [2:0]        cur_perr;
    logic              cur_fin;

    logic [7:0]        b;
    logic              is_space, is_digit, is_sign;
    logic [3:0]        base_flags, abs_flags;
    logic [ACC_W-1:0]  base_acc, abs_acc;
    logic [PROD_W-1:0] prod;
    logic [ACC_W-1:0]  tok_limit;
    logic [2:0]        tok_err;
    logic              emit;
    logic [2:0]        status;
    logic [15:0]       maxval;

    assign b        = item.data_byte;
    assign is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    assign is_digit = (b >= CH_0) && (b <= CH_9);
    assign is_sign  = (b == CH_PLUS) || (b == CH_MINUS);

    always_comb begin
        if (item.first_byte) begin
            cur_magic  = MP_P;
            cur_tphase = TP_IDLE;
            cur_tdone  = 2'd0;
            cur_acc    = '0;
            cur_flags  = '0;
            cur_perr   = pgm_hdr_pkg::ST_OK;
            cur_fin    = 1'b0;
        end else begin
            cur_magic  = magic_reg;
            cur_tphase = tphase_reg;
            cur_tdone  = tdone_reg;
            cur_acc    = acc_reg;
            cur_flags  = flags_reg;
            cur_perr   = perr_reg;
            cur_fin    = fin_reg;
        end
    end

    // absorb one byte into a token: continue the open one or start fresh
    always_comb begin
        base_flags = (cur_tphase == TP_TOKEN) ? cur_flags : 4'd0;
        base_acc   = (cur_tphase == TP_TOKEN) ? cur_acc : '0;
        prod       = PROD_W'({base_acc, 3'b000}) + PROD_W'({2'b00, base_acc, 1'b0})
                   + PROD_W'(b - CH_0);
        abs_flags  = base_flags;
        abs_acc    = base_acc;
        if ((base_flags == 4'd0) && is_sign) begin
            abs_flags[FLAG_SIGN] = 1'b1;
            abs_flags[FLAG_NEG]  = (b == CH_MINUS);
        end else if (is_digit) begin
            abs_flags[FLAG_DIGIT] = 1'b1;
            abs_acc = (prod > PROD_W'(ACC_CAP)) ? ACC_CAP : prod[ACC_W-1:0];
        end else begin
            abs_flags[FLAG_BAD] = 1'b1;
        end
    end

    // error of the token that ends on this byte
    always_comb begin
        tok_limit = (cur_tdone < 2'd2) ? DIM_LIMIT : MV_LIMIT;
        if (cur_flags[FLAG_BAD] || !cur_flags[FLAG_DIGIT]) begin
            tok_err = pgm_hdr_pkg::ST_BAD_NUMBER;
        end else if (cur_flags[FLAG_NEG] && (cur_acc != '0)) begin
            tok_err = pgm_hdr_pkg::ST_BAD_NUMBER;
        end else if (cur_acc > tok_limit) begin
            tok_err = pgm_hdr_pkg::ST_TOO_LARGE;
        end else begin
            tok_err = pgm_hdr_pkg::ST_OK;
        end
    end

    always_comb begin
        magic_next   = cur_magic;
        tphase_next  = cur_tphase;
        tdone_next   = cur_tdone;
        acc_next     = cur_acc;
        flags_next   = cur_flags;
        hwidth_next  = hwidth_reg;
        hheight_next = hheight_reg;
        perr_next    = cur_perr;
        fmt_next     = item.first_byte ? 1'b0 : fmt_reg;
        fin_next     = cur_fin;
        emit         = 1'b0;
        status       = pgm_hdr_pkg::ST_OK;
        maxval       = cur_acc[15:0];
        if (item.first_byte) begin
            hwidth_next  = '0;
            hheight_next = '0;
        end

        if (!cur_fin) begin
            unique case (cur_magic)
                MP_P: begin
                    if (b == CH_P) begin
                        magic_next = MP_DIGIT;
                    end else if (!is_space) begin
                        emit   = 1'b1;
                        status = pgm_hdr_pkg::ST_BAD_MAGIC;
                    end
                end
                MP_DIGIT: begin
                    if (b == CH_2) begin
                        fmt_next   = 1'b0;
                        magic_next = MP_SEP;
                    end else if (b == CH_5) begin
                        fmt_next   = 1'b1;
                        magic_next = MP_SEP;
                    end else begin
                        emit   = 1'b1;
                        status = pgm_hdr_pkg::ST_BAD_MAGIC;
                    end
                end
                MP_SEP: begin
                    if (is_space) begin
                        magic_next = MP_HDR;
                    end else begin
                        emit   = 1'b1;
                        status = pgm_hdr_pkg::ST_BAD_MAGIC;
                    end
                end
                default: begin
                    if (cur_tphase == TP_COMMENT) begin
                        if (b == CH_NL) begin
                            tphase_next = TP_IDLE;
                        end
                    end else if (cur_tphase == TP_TOKEN) begin
                        if (is_space || (b == CH_HASH)) begin
                            tphase_next = (b == CH_HASH) ? TP_COMMENT : TP_IDLE;
                            if (cur_perr == pgm_hdr_pkg::ST_OK) begin
                                perr_next = tok_err;
                            end
                            if (cur_tdone == 2'd0) begin
                                hwidth_next = cur_acc[15:0];
                            end
                            if (cur_tdone == 2'd1) begin
                                hheight_next = cur_acc[15:0];
                            end
                            tdone_next = cur_tdone + 2'd1;
                            if (cur_tdone == 2'd2) begin
                                emit   = 1'b1;
                                status = perr_next;
                            end
                        end else begin
                            acc_next   = abs_acc;
                            flags_next = abs_flags;
                        end
                    end else begin
                        if (b == CH_HASH) begin
                            tphase_next = TP_COMMENT;
                        end else if (!is_space) begin
                            tphase_next = TP_TOKEN;
                            acc_next    = abs_acc;
                            flags_next  = abs_flags;
                        end
                    end
                end
            endcase

            if (!emit && item.last_byte) begin
                emit   = 1'b1;
                status = ((magic_next == MP_P) || (magic_next == MP_DIGIT))
                       ? pgm_hdr_pkg::ST_BAD_MAGIC : pgm_hdr_pkg::ST_TRUNCATED;
            end
            if (emit) begin
                fin_next = 1'b1;
            end
        end
    end

    assign res_valid = emit;

    always_comb begin
        res.status        = status;
        res.image_width   = '0;
        res.image_height  = '0;
        res.max_value     = '0;
        res.binary_pixels = (status == pgm_hdr_pkg::ST_BAD_MAGIC) ? 1'b0 : fmt_next;
        if (status == pgm_hdr_pkg::ST_OK) begin
            res.image_width  = hwidth_next;
            res.image_height = hheight_next;
            res.max_value    = maxval;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            magic_reg   <= MP_P;
            tphase_reg  <= TP_IDLE;
            tdone_reg   <= 2'd0;
            acc_reg     <= '0;
            flags_reg   <= '0;
            hwidth_reg  <= '0;
            hheight_reg <= '0;
            perr_reg    <= pgm_hdr_pkg::ST_OK;
            fmt_reg     <= 1'b0;
            fin_reg     <= 1'b0;
        end else if (proc_en) begin
            magic_reg   <= magic_next;
            tphase_reg  <= tphase_next;
            tdone_reg   <= tdone_next;
            acc_reg     <= acc_next;
            flags_reg   <= flags_next;
            hwidth_reg  <= hwidth_next;
            hheight_reg <= hheight_next;
            perr_reg    <= perr_next;
            fmt_reg     <= fmt_next;
            fin_reg     <= fin_next;
        end
    end

    a_result_closes_file: assert property (@(posedge clk) disable iff (!rstn)
        proc_en && res_valid |=> fin_reg)
        else $error("parser still active after giving its result");

    a_quiet_after_result: assert property (@(posedge clk) disable iff (!rstn)
        proc_en && fin_reg && !item.first_byte |-> !res_valid)
        else $error("second result within one file");

    a_last_byte_answers: assert property (@(posedge clk) disable iff (!rstn)
        proc_en && item.last_byte && (!fin_reg || item.first_byte) |-> res_valid)
        else $error("final byte of an open file gave no result");

    a_token_count: assert property (@(posedge clk) disable iff (!rstn)
        !fin_reg |-> (tdone_reg != 2'd3))
        else $error("token count ran past three in an open header");

endmodule

`default_nettype wire

@@ src/pgm_hdr_out_stage.sv @@
// Result register: holds one result item until the downstream side takes it.
`default_nettype none

module pgm_hdr_out_stage (
    input  wire logic                   clk,
    input  wire logic                   rstn,
    input  wire logic                   load,
    input  wire logic                   res_valid,
    input  wire pgm_hdr_pkg::res_item_t res,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output pgm_hdr_pkg::res_item_t      m_item
);

    logic                   valid_reg;
    pgm_hdr_pkg::res_item_t item_reg;

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= res_valid;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (load && res_valid) begin
            item_reg <= res;
        end
    end

endmodule

`default_nettype wire
